@@ src/ihs_pkg.sv @@
package ihs_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int ADDR_W    = 4;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [1:0] REG_DIFF = 2'd0;
  localparam logic [1:0] REG_FLUX = 2'd1;
  localparam logic [1:0] REG_LAST = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE, OP_FETCH, OP_N0_MUL, OP_N0_DC, OP_N0_DD, OP_M_G0, OP_M_G1, OP_M_DC,
    OP_M_DD, OP_L_MULK, OP_L_E, OP_L_B, OP_L_MUL1, OP_L_MUL2, OP_L_XN, OP_L_MUL3,
    OP_L_U1, OP_BS_RD, OP_BS_MUL, OP_BS_WR, OP_EM_RD, OP_EM_LD, OP_EM_WAIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic div_start;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic p_zero;
    logic p_last;
    logic ptr_zero;
    logic ptr_last;
    logic div_busy;
    logic div_done;
    logic out_fire;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'(S32_MAX)) r = S32_MAX;
    else if (v < 36'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Q16.16 product: round half away from zero, saturate
  function automatic logic signed [31:0] mul_round(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] m;
    logic [47:0] t;
    logic signed [31:0] r;
    neg = p[63];
    m   = neg ? 64'(-p) : 64'(p);
    t   = 48'((m + 64'd32768) >> 16);
    if (t >= 48'h8000_0000) r = neg ? S32_MIN : S32_MAX;
    else r = neg ? -$signed(t[31:0]) : $signed(t[31:0]);
    return r;
  endfunction

endpackage

@@ src/ihs_in_if.sv @@
interface ihs_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] node_value;
  logic signed [31:0] boundary_flux;

  modport source (output valid, cmd, node_value, boundary_flux, input ready);
  modport sink (input valid, cmd, node_value, boundary_flux, output ready);
endinterface

@@ src/ihs_out_if.sv @@
interface ihs_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         node_index;
  logic signed [31:0] solved_value;
  logic               last;

  modport source (output valid, node_index, solved_value, last, input ready);
  modport sink (input valid, node_index, solved_value, last, output ready);
endinterface

@@ src/ihs_div.sv @@
module ihs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [34:0] num_i,
  input  logic signed [34:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import ihs_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_PRE  = 3'b010,
    DV_ITER = 3'b100
  } dv_state_e;

  dv_state_e          state_q, state_d;
  logic [50:0]        nsum_q;
  logic [33:0]        md_q;
  logic [33:0]        rem_q;
  logic [32:0]        q_q;
  logic [5:0]         cnt_q;
  logic               neg_q, nneg_q, done_q;
  logic signed [31:0] res_q;

  logic [33:0] an, ad;
  logic [34:0] trial;
  logic        ge;
  logic [32:0] qn;
  logic signed [31:0] sat_res, fin_res;

  assign an      = num_i[34] ? 34'(-num_i) : num_i[33:0];
  assign ad      = den_i[34] ? 34'(-den_i) : den_i[33:0];
  assign trial   = {rem_q, nsum_q[cnt_q]};
  assign ge      = trial >= {1'b0, md_q};
  assign qn      = {q_q[31:0], ge};
  assign sat_res = neg_q ? S32_MIN : S32_MAX;
  assign fin_res = (qn >= 33'h0_8000_0000) ? sat_res :
                   (neg_q ? -$signed(qn[31:0]) : $signed(qn[31:0]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (start_i) state_d = DV_PRE;
      DV_PRE: begin
        if (md_q == '0 || {16'b0, nsum_q} >= {md_q, 33'b0}) state_d = DV_IDLE;
        else state_d = DV_ITER;
      end
      DV_ITER: if (cnt_q == '0) state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DV_PRE && state_d == DV_IDLE) ||
                 (state_q == DV_ITER && cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          nsum_q <= 51'({an, 16'b0}) + 51'(ad >> 1);
          md_q   <= ad;
          nneg_q <= num_i[34];
          neg_q  <= num_i[34] ^ den_i[34];
        end
      end
      DV_PRE: begin
        if (md_q == '0) res_q <= nneg_q ? S32_MIN : S32_MAX;
        else res_q <= sat_res;
        rem_q <= 34'(nsum_q[50:33]);
        q_q   <= '0;
        cnt_q <= 6'd32;
      end
      DV_ITER: begin
        rem_q <= ge ? 34'(trial - {1'b0, md_q}) : trial[33:0];
        q_q   <= qn;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) res_q <= fin_res;
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != DV_IDLE;
  assign done_o = done_q;
  assign quo_o  = res_q;
endmodule

@@ src/ihs_datapath.sv @@
module ihs_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ihs_pkg::cmd_t  cmd_i,
  output ihs_pkg::stat_t stat_o,
  input  logic [30:0]    diffusion_ratio_i,
  input  logic [30:0]    flux_gain_i,
  input  logic [5:0]     last_node_i,
  ihs_in_if.sink         in_i,
  ihs_out_if.source      out_o
);
  import ihs_pkg::*;

  logic signed [31:0] row_mem  [MAX_NODES];
  logic signed [31:0] coef_mem [MAX_NODES];
  logic signed [31:0] rhs_mem  [MAX_NODES];

  logic [IDX_W-1:0]   cnt_q, p_q, ptr_q;
  logic signed [31:0] val_q, flux_q, g_q, s_q, e_q, b_q, u_q;
  logic signed [32:0] det_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] row_rd_q, coef_rd_q, rhs_rd_q;
  logic               out_valid_q, out_last_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic signed [31:0] out_val_q;

  logic [IDX_W-1:0]   nl, p_c, row_waddr, row_raddr, sw_raddr;
  logic               in_fire, out_fire, row_we, row_re, sw_re, mul_en;
  logic signed [31:0] row_wdata, r_s, k_s, mulres, bs_val, mul_a, mul_b, div_q;
  logic signed [32:0] opr, piv;
  logic signed [34:0] div_num, div_den;
  logic               div_busy, div_done;

  assign nl       = (last_node_i < 6'd2) ? IDX_W'(2) : last_node_i;
  assign p_c      = (cnt_q > nl) ? nl : cnt_q;
  assign in_fire  = cmd_i.in_ready & in_i.valid;
  assign out_fire = out_valid_q & out_o.ready;
  assign r_s      = $signed({1'b0, diffusion_ratio_i});
  assign k_s      = $signed({1'b0, flux_gain_i});
  assign opr      = 33'(ONE_Q16) + 33'(r_s);
  assign piv      = 33'(coef_rd_q) + 33'(g_q);
  assign mulres   = mul_round(prod_q);
  assign bs_val   = sat32(36'(rhs_rd_q) - 36'(mulres));

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_N0_MUL, OP_L_MULK: begin mul_a = k_s;       mul_b = flux_q; end
      OP_L_MUL1:            begin mul_a = coef_rd_q; mul_b = e_q;    end
      OP_L_MUL2:            begin mul_a = e_q;       mul_b = rhs_rd_q; end
      OP_L_MUL3, OP_BS_MUL: begin mul_a = coef_rd_q; mul_b = u_q;    end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.op)
      OP_N0_DC, OP_L_E: begin div_num = -35'(r_s); div_den = 35'(opr); end
      OP_N0_DD: begin
        div_num = 35'(sat32(36'(row_rd_q) + 36'(val_q) - 36'(mulres)));
        div_den = 35'(opr);
      end
      OP_M_G0: begin
        div_num = 35'(sat32(36'(row_rd_q) + 36'(val_q)));
        div_den = -35'(r_s);
      end
      OP_M_G1: begin div_num = 35'(ONE_Q16) + 35'(r_s) + 35'(r_s); div_den = 35'(r_s); end
      OP_M_DC: begin div_num = -35'(ONE_Q16); div_den = 35'(piv); end
      OP_M_DD: begin div_num = 35'(s_q); div_den = 35'(piv); end
      OP_L_B: begin
        div_num = 35'(sat32(36'(row_rd_q) + 36'(val_q) + 36'(mulres)));
        div_den = 35'(opr);
      end
      OP_L_XN: begin
        div_num = 35'(sat32(36'(b_q) - 36'(mulres)));
        div_den = 35'(det_q);
      end
      default: ;
    endcase
  end

  ihs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  always_comb begin
    row_we    = 1'b0;
    row_waddr = p_c;
    row_wdata = in_i.node_value;
    if (in_fire && in_i.cmd == CMD_LOAD) begin
      row_we = 1'b1;
    end else if (cmd_i.op == OP_L_XN && div_done) begin
      row_we    = 1'b1;
      row_waddr = nl;
      row_wdata = div_q;
    end else if (cmd_i.op == OP_L_U1) begin
      row_we    = 1'b1;
      row_waddr = nl - IDX_W'(1);
      row_wdata = bs_val;
    end else if (cmd_i.op == OP_BS_WR) begin
      row_we    = 1'b1;
      row_waddr = ptr_q;
      row_wdata = bs_val;
    end
  end

  assign row_re    = (cmd_i.op == OP_FETCH) || (cmd_i.op == OP_EM_RD);
  assign row_raddr = (cmd_i.op == OP_FETCH) ? p_q : ptr_q;
  assign sw_re     = (cmd_i.op == OP_FETCH) || (cmd_i.op == OP_BS_RD);
  assign sw_raddr  = ((cmd_i.op == OP_FETCH) ? p_q : ptr_q) - IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_N0_DC || cmd_i.op == OP_M_DC) && div_done) coef_mem[p_q] <= div_q;
    if (sw_re) coef_rd_q <= coef_mem[sw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_N0_DD || cmd_i.op == OP_M_DD) && div_done) rhs_mem[p_q] <= div_q;
    if (sw_re) rhs_rd_q <= rhs_mem[sw_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      p_q         <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= (p_c == nl) ? '0 : p_c + IDX_W'(1);
        p_q   <= p_c;
      end
      case (cmd_i.op)
        OP_L_U1: ptr_q <= nl - IDX_W'(1);
        OP_BS_RD: ptr_q <= ptr_q - IDX_W'(1);
        OP_EM_WAIT: if (out_fire && ptr_q != nl) ptr_q <= ptr_q + IDX_W'(1);
        default: ;
      endcase
      if (cmd_i.op == OP_EM_LD) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q  <= in_i.node_value;
      flux_q <= in_i.boundary_flux;
    end
    if (mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
    case (cmd_i.op)
      OP_M_G0: if (div_done) s_q <= sat32(36'(rhs_rd_q) - 36'(div_q));
      OP_M_G1: if (div_done) g_q <= div_q;
      OP_L_E:  if (div_done) e_q <= div_q;
      OP_L_B:  if (div_done) b_q <= div_q;
      OP_L_XN: if (div_done) u_q <= div_q;
      OP_L_MUL2: det_q <= 33'(ONE_Q16) - 33'(mulres);
      OP_L_U1, OP_BS_WR: u_q <= bs_val;
      OP_EM_LD: begin
        out_idx_q  <= ptr_q;
        out_val_q  <= row_rd_q;
        out_last_q <= ptr_q == nl;
      end
      default: ;
    endcase
  end

  assign in_i.ready         = cmd_i.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.node_index   = out_idx_q;
  assign out_o.solved_value = out_val_q;
  assign out_o.last         = out_last_q;

  assign stat_o.in_valid = in_i.valid;
  assign stat_o.in_cmd   = in_i.cmd;
  assign stat_o.p_zero   = p_q == '0;
  assign stat_o.p_last   = p_q == nl;
  assign stat_o.ptr_zero = ptr_q == '0;
  assign stat_o.ptr_last = ptr_q == nl;
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign stat_o.out_fire = out_fire;
endmodule

@@ src/ihs_ctrl.sv @@
module ihs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ihs_pkg::stat_t stat_i,
  output ihs_pkg::cmd_t  cmd_o
);
  import ihs_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE    = 23'(1) << 0,
    S_FETCH   = 23'(1) << 1,
    S_N0_MUL  = 23'(1) << 2,
    S_N0_DC   = 23'(1) << 3,
    S_N0_DD   = 23'(1) << 4,
    S_M_G0    = 23'(1) << 5,
    S_M_G1    = 23'(1) << 6,
    S_M_DC    = 23'(1) << 7,
    S_M_DD    = 23'(1) << 8,
    S_L_MULK  = 23'(1) << 9,
    S_L_E     = 23'(1) << 10,
    S_L_B     = 23'(1) << 11,
    S_L_MUL1  = 23'(1) << 12,
    S_L_MUL2  = 23'(1) << 13,
    S_L_XN    = 23'(1) << 14,
    S_L_MUL3  = 23'(1) << 15,
    S_L_U1    = 23'(1) << 16,
    S_BS_RD   = 23'(1) << 17,
    S_BS_MUL  = 23'(1) << 18,
    S_BS_WR   = 23'(1) << 19,
    S_EM_RD   = 23'(1) << 20,
    S_EM_LD   = 23'(1) << 21,
    S_EM_WAIT = 23'(1) << 22
  } state_e;

  state_e state_q, state_d;
  op_e    op;
  logic   is_div;

  always_comb begin
    op     = OP_IDLE;
    is_div = 1'b0;
    case (state_q)
      S_IDLE:    op = OP_IDLE;
      S_FETCH:   op = OP_FETCH;
      S_N0_MUL:  op = OP_N0_MUL;
      S_N0_DC:   begin op = OP_N0_DC; is_div = 1'b1; end
      S_N0_DD:   begin op = OP_N0_DD; is_div = 1'b1; end
      S_M_G0:    begin op = OP_M_G0;  is_div = 1'b1; end
      S_M_G1:    begin op = OP_M_G1;  is_div = 1'b1; end
      S_M_DC:    begin op = OP_M_DC;  is_div = 1'b1; end
      S_M_DD:    begin op = OP_M_DD;  is_div = 1'b1; end
      S_L_MULK:  op = OP_L_MULK;
      S_L_E:     begin op = OP_L_E;   is_div = 1'b1; end
      S_L_B:     begin op = OP_L_B;   is_div = 1'b1; end
      S_L_MUL1:  op = OP_L_MUL1;
      S_L_MUL2:  op = OP_L_MUL2;
      S_L_XN:    begin op = OP_L_XN;  is_div = 1'b1; end
      S_L_MUL3:  op = OP_L_MUL3;
      S_L_U1:    op = OP_L_U1;
      S_BS_RD:   op = OP_BS_RD;
      S_BS_MUL:  op = OP_BS_MUL;
      S_BS_WR:   op = OP_BS_WR;
      S_EM_RD:   op = OP_EM_RD;
      S_EM_LD:   op = OP_EM_LD;
      S_EM_WAIT: op = OP_EM_WAIT;
      default:   op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (stat_i.in_valid && stat_i.in_cmd == CMD_STEP) state_d = S_FETCH;
      S_FETCH: begin
        if (stat_i.p_zero) state_d = S_N0_MUL;
        else if (stat_i.p_last) state_d = S_L_MULK;
        else state_d = S_M_G0;
      end
      S_N0_MUL:  state_d = S_N0_DC;
      S_N0_DC:   if (stat_i.div_done) state_d = S_N0_DD;
      S_N0_DD:   if (stat_i.div_done) state_d = S_IDLE;
      S_M_G0:    if (stat_i.div_done) state_d = S_M_G1;
      S_M_G1:    if (stat_i.div_done) state_d = S_M_DC;
      S_M_DC:    if (stat_i.div_done) state_d = S_M_DD;
      S_M_DD:    if (stat_i.div_done) state_d = S_IDLE;
      S_L_MULK:  state_d = S_L_E;
      S_L_E:     if (stat_i.div_done) state_d = S_L_B;
      S_L_B:     if (stat_i.div_done) state_d = S_L_MUL1;
      S_L_MUL1:  state_d = S_L_MUL2;
      S_L_MUL2:  state_d = S_L_XN;
      S_L_XN:    if (stat_i.div_done) state_d = S_L_MUL3;
      S_L_MUL3:  state_d = S_L_U1;
      S_L_U1:    state_d = S_BS_RD;
      S_BS_RD:   state_d = S_BS_MUL;
      S_BS_MUL:  state_d = S_BS_WR;
      S_BS_WR:   state_d = stat_i.ptr_zero ? S_EM_RD : S_BS_RD;
      S_EM_RD:   state_d = S_EM_LD;
      S_EM_LD:   state_d = S_EM_WAIT;
      S_EM_WAIT: begin
        if (stat_i.out_fire) state_d = stat_i.ptr_last ? S_IDLE : S_EM_RD;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign cmd_o.op        = op;
  assign cmd_o.div_start = is_div & ~stat_i.div_busy & ~stat_i.div_done;
  assign cmd_o.in_ready  = state_q == S_IDLE;
endmodule

@@ src/implicit_heat_step_thomas_solver_top.sv @@
// Load beat: written to the row memory while idle; ready stays high.
// Step beat: each quotient comes from the shared serial divider. Node 0 and inner
// nodes run the forward sweep only; node N also runs back substitution over all
// rows, then gives one result beat per row, each held until it is taken.
// One beat is in work at a time. Async active-low reset clears the sequencer and
// node counter, presets config registers; row and sweep memories are not cleared.
module implicit_heat_step_thomas_solver_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ihs_in_if.sink                     in_i,
  ihs_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ihs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ihs_pkg::*;

  logic [30:0] diff_q, flux_q;
  logic [5:0]  last_q;
  logic        wr_en;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= 31'h0001_0000;
      flux_q <= 31'h0001_0000;
      last_q <= 6'd63;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DIFF: diff_q <= pwdata[30:0];
        REG_FLUX: flux_q <= pwdata[30:0];
        REG_LAST: last_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIFF: prdata = {1'b0, diff_q};
      REG_FLUX: prdata = {1'b0, flux_q};
      REG_LAST: prdata = {26'b0, last_q};
      default:  prdata = '0;
    endcase
  end

  ihs_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  ihs_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .diffusion_ratio_i(diff_q),
    .flux_gain_i      (flux_q),
    .last_node_i      (last_q),
    .in_i             (in_i),
    .out_o            (out_o)
  );
endmodule
